/* design/kcg_pkg.sv */
package kcg_pkg;

  // field widths fixed by the channel definitions
  localparam int SYM_BITS   = 5;
  localparam int CHAR_W     = 8;
  localparam int CODE_W     = 60;
  localparam int WLEN_W     = 4;

  // default and largest window in symbols
  localparam int MAX_WINDOW_DEF = 12;

  // window length after reset
  localparam logic [WLEN_W-1:0] WLEN_RESET = 4'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_UC_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_B = 8'h42;
  localparam logic [CHAR_W-1:0] CH_UC_J = 8'h4A;
  localparam logic [CHAR_W-1:0] CH_UC_O = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_UC_U = 8'h55;
  localparam logic [CHAR_W-1:0] CH_UC_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UC_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z = 8'h7A;

  // decoded symbol
  typedef struct packed {
    logic                ok;
    logic [SYM_BITS-1:0] code;
  } sym_dec_t;

  // one result transaction
  typedef struct packed {
    logic [CODE_W-1:0] kmer_code;
    logic              code_valid;
    logic              seq_end;
  } kmer_result_t;

endpackage

/* design/kcg_if.sv */
// symbol input channel
interface kcg_in_if;
  logic                        valid;
  logic                        ready;
  logic [kcg_pkg::CHAR_W-1:0]  symbol;
  logic                        seq_last;

  modport source (output valid, output symbol, output seq_last, input ready);
  modport sink   (input valid, input symbol, input seq_last, output ready);
endinterface

// k-mer result channel
interface kcg_out_if;
  logic                        valid;
  logic                        ready;
  logic [kcg_pkg::CODE_W-1:0]  kmer_code;
  logic                        code_valid;
  logic                        seq_end;

  modport source (output valid, output kmer_code, output code_valid, output seq_end,
                  input ready);
  modport sink   (input valid, input kmer_code, input code_valid, input seq_end,
                  output ready);
endinterface

// window length write channel
interface kcg_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kcg_pkg::WLEN_W-1:0]  window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

/* design/kcg_sym_decode.sv */
module kcg_sym_decode (
  input  logic [kcg_pkg::CHAR_W-1:0] symbol,
  output kcg_pkg::sym_dec_t          dec
);
  import kcg_pkg::*;

  logic [CHAR_W-1:0] offset;

  // letters fold to 0..25, ambiguous and stop codes rejected
  always_comb begin
    offset   = '0;
    dec.ok   = 1'b0;
    if (symbol == CH_UC_X || symbol == CH_UC_B || symbol == CH_UC_J ||
        symbol == CH_UC_O || symbol == CH_UC_U || symbol == CH_STAR) begin
      dec.ok = 1'b0;
    end else if (symbol inside {[CH_LC_A:CH_LC_Z]}) begin
      offset = symbol - CH_LC_A;
      dec.ok = 1'b1;
    end else if (symbol inside {[CH_UC_A:CH_UC_Z]}) begin
      offset = symbol - CH_UC_A;
      dec.ok = 1'b1;
    end
    dec.code = offset[SYM_BITS-1:0];
  end

endmodule

/* design/kcg_window.sv */
module kcg_window #(
  parameter int MAX_WINDOW = kcg_pkg::MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  kcg_pkg::sym_dec_t          dec,
  input  logic                       seq_last,
  input  logic [kcg_pkg::WLEN_W-1:0] window_len,
  output kcg_pkg::kmer_result_t      result
);
  import kcg_pkg::*;

  localparam int HIST_W = MAX_WINDOW * SYM_BITS;
  localparam int RUN_W  = $clog2(MAX_WINDOW + 1);

  logic [HIST_W-1:0] history;
  logic [HIST_W-1:0] history_next;
  logic [RUN_W-1:0]  run;
  logic [RUN_W-1:0]  run_next;
  logic [WLEN_W-1:0] k_eff;
  logic [HIST_W-1:0] masked;

  // shift in the new symbol and extend the run of good symbols
  always_comb begin
    history_next = HIST_W'(history << SYM_BITS)
                 | HIST_W'(dec.ok ? dec.code : '0);
    if (!dec.ok) begin
      run_next = '0;
    end else if (run < RUN_W'(MAX_WINDOW)) begin
      run_next = run + 1'b1;
    end else begin
      run_next = run;
    end
  end

  // clamp window length to 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      k_eff = WLEN_W'(1);
    end else if (window_len > WLEN_W'(MAX_WINDOW)) begin
      k_eff = WLEN_W'(MAX_WINDOW);
    end else begin
      k_eff = window_len;
    end
  end

  // keep only the newest k symbol lanes
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      masked[i*SYM_BITS +: SYM_BITS] =
        (WLEN_W'(i) < k_eff) ? history_next[i*SYM_BITS +: SYM_BITS] : '0;
    end
  end

  // result of the current transaction
  always_comb begin
    result.code_valid = (WLEN_W'(run_next) >= k_eff);
    result.kmer_code  = result.code_valid ? CODE_W'(masked) : '0;
    result.seq_end    = seq_last;
  end

  // window state, cleared after the last symbol of a sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      run     <= '0;
    end else if (accept) begin
      if (seq_last) begin
        history <= '0;
        run     <= '0;
      end else begin
        history <= history_next;
        run     <= run_next;
      end
    end
  end

endmodule

/* design/protein_kmer_code_generator_top.sv */
// channel   direction  transaction
// sym_in    in         symbol[7:0], seq_last
// code_out  out        kmer_code[59:0], code_valid, seq_end
// cfg       in         window_len[3:0]
//
// One symbol a cycle while code_out is not stalled; each result appears in the cycle after its symbol is taken,
// from a single output register fed by the decode and window logic.
// The symbol history and run counter update in the same cycle a symbol is taken.
// Reset (rst, synchronous) clears the window state, empties the output
// register and sets the window length to 3.
// When code_out is stalled with a result held, sym_in waits; otherwise both flow.
module protein_kmer_code_generator_top #(
  parameter int MAX_WINDOW = kcg_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  kcg_in_if.sink      sym_in,
  kcg_out_if.source   code_out,
  kcg_cfg_if.sink     cfg
);
  import kcg_pkg::*;

  logic              accept;
  logic [WLEN_W-1:0] window_len;
  sym_dec_t          dec;
  kmer_result_t      result;
  kmer_result_t      out_reg;
  logic              out_full;

  // input taken whenever the output register is free or draining
  assign sym_in.ready = !out_full || code_out.ready;
  assign accept       = sym_in.valid && sym_in.ready;

  // window length register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WLEN_RESET;
    end else if (cfg.valid) begin
      window_len <= cfg.window_len;
    end
  end

  kcg_sym_decode u_decode (
    .symbol (sym_in.symbol),
    .dec    (dec)
  );

  kcg_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .dec        (dec),
    .seq_last   (sym_in.seq_last),
    .window_len (window_len),
    .result     (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (accept) begin
      out_full <= 1'b1;
    end else if (code_out.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign code_out.valid      = out_full;
  assign code_out.kmer_code  = out_reg.kmer_code;
  assign code_out.code_valid = out_reg.code_valid;
  assign code_out.seq_end    = out_reg.seq_end;

endmodule
